FILE: hw/rtl/cgt_pkg.sv
// Package for the color gradient timeline unit.
// Types, sequencer states and reset tables shared by all files; no dependencies.
package cgt_pkg;

  localparam int DIV_W = 24;   // dividend / quotient width of the shared divider
  localparam int DEN_W = 16;   // divisor width

  typedef logic [7:0]  byte_t;
  typedef logic [23:0] rgb_t;

  typedef enum logic [1:0] {
    FN_EVAL   = 2'd0,
    FN_SET    = 2'd1,
    FN_ADD    = 2'd2,
    FN_REMOVE = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_RATIO,
    S_DIV,
    S_COLL,
    S_COLR,
    S_BLEND,
    S_SET,
    S_RS_RD,
    S_RS_DIV,
    S_RS_FIN,
    S_OUT
  } state_t;

  localparam int    INIT_N = 4;
  localparam byte_t INIT_TIMES [INIT_N] = '{8'd0, 8'd85, 8'd170, 8'd255};
  localparam rgb_t  INIT_COLORS[INIT_N] = '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFF0000};

  // Widened time point: t<<8 | t
  function automatic logic [15:0] widen(input byte_t t);
    return {t, t};
  endfunction

  // x/255 for x <= 65025
  function automatic byte_t div255(input logic [15:0] x);
    logic [15:0] s;
    s = x + 16'd1 + {8'd0, x[15:8]};
    return s[15:8];
  endfunction

endpackage

FILE: hw/rtl/cgt_if.sv
// Channel interfaces of the color gradient timeline unit.
// Depends on cgt_pkg.
interface cgt_in_if import cgt_pkg::*; ();
  logic  valid;
  logic  ready;
  func_e func;
  logic [15:0] time_progress;
  logic [2:0]  marker_index;
  byte_t marker_time;
  byte_t marker_red;
  byte_t marker_green;
  byte_t marker_blue;

  modport source (output valid, func, time_progress, marker_index, marker_time,
                  marker_red, marker_green, marker_blue, input ready);
  modport sink   (input valid, func, time_progress, marker_index, marker_time,
                  marker_red, marker_green, marker_blue, output ready);
endinterface

interface cgt_out_if import cgt_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t red;
  byte_t green;
  byte_t blue;
  logic [3:0] count_now;
  logic  request_ignored;

  modport source (output valid, red, green, blue, count_now, request_ignored,
                  input ready);
  modport sink   (input valid, red, green, blue, count_now, request_ignored,
                  output ready);
endinterface

FILE: hw/rtl/cgt_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on cgt_pkg.
module cgt_div import cgt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DIV_W-1:0] q_r;
  logic             done_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  assign trial = {rem_r, q_r[DIV_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(DIV_W);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= dividend;
      den_r <= divisor;
    end else if (cnt_r != '0) begin
      if (!diff[DEN_W]) begin
        rem_r <= diff[DEN_W-1:0];
        q_r   <= {q_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DEN_W-1:0];
        q_r   <= {q_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: hw/rtl/color_gradient_timeline_unit.sv
// Color gradient timeline unit: marker table, sequencer and blend datapath.
// Depends on cgt_pkg, cgt_if and cgt_div.
//
// One request is taken at a time; ready is low until its result beat has been
// taken. Evaluate walks the marker pairs one table read per cycle, runs the
// shared 24-step divider for the ratio (skipped when the progress sits on or
// outside the pair ends), reads the two colors and blends one channel per
// cycle. Add and remove rescale each time point through the same divider, one
// marker at a time; refused requests go straight to the result beat.
module color_gradient_timeline_unit import cgt_pkg::*; #(
  parameter int MAX_MARKERS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  cgt_in_if.sink    in_bus,
  cgt_out_if.source out_bus
);

  localparam int IW = $clog2(MAX_MARKERS);
  localparam int CW = $clog2(MAX_MARKERS + 1);
  localparam int RESET_N = (MAX_MARKERS < INIT_N) ? MAX_MARKERS : INIT_N;

  state_t state_r, state_nxt;

  byte_t   tp_r  [MAX_MARKERS];
  rgb_t    col_r [MAX_MARKERS];
  logic [CW-1:0] cnt_r;

  func_e       func_r;
  logic [15:0] prog_r;
  logic [2:0]  idx_r;
  byte_t       mtime_r;
  rgb_t        mcolor_r;

  logic [IW-1:0] i_r;
  logic [IW-1:0] pos_r;
  byte_t   l_r, r_r, ratio_r;
  rgb_t    cl_r, cr_r;
  logic [1:0] ch_r;
  byte_t   red_r, green_r, blue_r;
  logic    ign_r;

  byte_t   tp_rd;
  rgb_t    col_rd;
  logic    hit;
  logic    last_pair;
  logic [15:0] lw, rw;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DEN_W-1:0] div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_q;

  logic [CW-1:0] n_m1;
  logic [15:0]   mix;
  byte_t         ch_val;
  byte_t         sat_q;

  assign tp_rd  = tp_r[i_r];
  assign col_rd = col_r[i_r];
  assign n_m1   = cnt_r - 1'b1;
  assign lw     = widen(l_r);
  assign rw     = widen(r_r);
  assign hit    = (prog_r >= lw) && (prog_r <= widen(tp_rd));
  assign last_pair = (CW'(i_r) == n_m1);

  assign mix    = 16'(cl_r[23:16] * (8'd255 - ratio_r)) + 16'(cr_r[23:16] * ratio_r);
  assign ch_val = div255(mix);
  assign sat_q  = (div_q > DIV_W'(255)) ? 8'd255 : div_q[7:0];

  cgt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_W'(8'd255) * DIV_W'(prog_r - lw);
    div_divisor  = rw - lw;
    if (state_r == S_RATIO) begin
      div_start = (prog_r > lw) && (prog_r < rw);
    end else if (state_r == S_RS_RD) begin
      div_start    = (i_r != pos_r);
      div_dividend = DIV_W'(tp_rd) * DIV_W'(n_m1);
      div_divisor  = (func_r == FN_ADD) ? DEN_W'(cnt_r) : DEN_W'(cnt_r - CW'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_bus.valid) begin
          case (in_bus.func)
            FN_EVAL:   state_nxt = S_SCAN;
            FN_SET:    state_nxt = S_SET;
            FN_ADD:    state_nxt = (32'(cnt_r) >= MAX_MARKERS) ? S_OUT : S_RS_RD;
            FN_REMOVE: state_nxt = (cnt_r <= CW'(2)) ? S_OUT : S_RS_RD;
            default:   state_nxt = S_OUT;
          endcase
        end
      end
      S_SCAN:   if (i_r != '0 && (hit || last_pair)) state_nxt = S_RATIO;
      S_RATIO:  state_nxt = div_start ? S_DIV : S_COLL;
      S_DIV:    if (div_done) state_nxt = S_COLL;
      S_COLL:   state_nxt = S_COLR;
      S_COLR:   state_nxt = S_BLEND;
      S_BLEND:  if (ch_r == 2'd2) state_nxt = S_OUT;
      S_SET:    state_nxt = S_OUT;
      S_RS_RD:  state_nxt = (i_r == pos_r) ? S_RS_FIN : S_RS_DIV;
      S_RS_DIV: if (div_done) state_nxt = S_RS_RD;
      S_RS_FIN: state_nxt = S_OUT;
      S_OUT:    if (out_bus.ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Table and count: reset loads the default gradient.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_MARKERS; k++) begin
        tp_r[k]  <= (k < RESET_N) ? INIT_TIMES[k % INIT_N]  : '0;
        col_r[k] <= (k < RESET_N) ? INIT_COLORS[k % INIT_N] : '0;
      end
      cnt_r <= CW'(RESET_N);
    end else begin
      case (state_r)
        S_SET: begin
          if (32'(idx_r) < MAX_MARKERS) begin
            tp_r[IW'(idx_r)]  <= mtime_r;
            col_r[IW'(idx_r)] <= mcolor_r;
            if (idx_r == 3'd0)
              col_r[IW'(n_m1)] <= mcolor_r;
            else if (32'(idx_r) == 32'(n_m1))
              col_r[0] <= mcolor_r;
          end
        end
        S_RS_DIV: if (div_done) tp_r[i_r] <= sat_q;
        S_RS_FIN: begin
          tp_r[pos_r]  <= 8'd255;
          col_r[pos_r] <= col_r[0];
          cnt_r <= (func_r == FN_ADD) ? cnt_r + 1'b1 : n_m1;
        end
        default: ;
      endcase
    end
  end

  // Request capture and working registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        func_r   <= in_bus.func;
        prog_r   <= in_bus.time_progress;
        idx_r    <= in_bus.marker_index;
        mtime_r  <= in_bus.marker_time;
        mcolor_r <= {in_bus.marker_red, in_bus.marker_green, in_bus.marker_blue};
        i_r      <= '0;
        ch_r     <= '0;
        red_r    <= '0;
        green_r  <= '0;
        blue_r   <= '0;
        pos_r    <= (in_bus.func == FN_ADD) ? IW'(cnt_r) : IW'(cnt_r - CW'(2));
        ign_r    <= ((in_bus.func == FN_ADD) && (32'(cnt_r) >= MAX_MARKERS)) ||
                    ((in_bus.func == FN_REMOVE) && (cnt_r <= CW'(2)));
      end
      S_SCAN: begin
        if (i_r == '0) begin
          l_r <= tp_rd;
          i_r <= i_r + 1'b1;
        end else begin
          r_r <= tp_rd;
          if (hit || last_pair) begin
            i_r <= i_r - 1'b1;     // point at left marker of the chosen pair
          end else begin
            l_r <= tp_rd;
            i_r <= i_r + 1'b1;
          end
        end
      end
      S_RATIO: ratio_r <= (prog_r <= lw) ? 8'd0 : 8'd255;
      S_DIV:   if (div_done) ratio_r <= div_q[7:0];
      S_COLL: begin
        cl_r <= col_rd;
        i_r  <= i_r + 1'b1;
      end
      S_COLR: cr_r <= col_rd;
      S_BLEND: begin
        case (ch_r)
          2'd0:    red_r   <= ch_val;
          2'd1:    green_r <= ch_val;
          default: blue_r  <= ch_val;
        endcase
        cl_r <= {cl_r[15:0], 8'd0};
        cr_r <= {cr_r[15:0], 8'd0};
        ch_r <= ch_r + 1'b1;
      end
      S_RS_DIV: if (div_done) i_r <= i_r + 1'b1;
      default: ;
    endcase
  end

  assign in_bus.ready            = (state_r == S_IDLE);
  assign out_bus.valid           = (state_r == S_OUT);
  assign out_bus.red             = red_r;
  assign out_bus.green           = green_r;
  assign out_bus.blue            = blue_r;
  assign out_bus.count_now       = 4'(cnt_r);
  assign out_bus.request_ignored = ign_r;

endmodule

FILE: test/color_gradient_timeline_unit_tb.sv
// Testbench for color_gradient_timeline_unit: random and directed marker-table traffic.
// A scoreboard class predicts each result beat; depends on cgt_pkg, cgt_if and the RTL.
module color_gradient_timeline_unit_tb;
  import cgt_pkg::*;

  localparam int MAXM = 8;

  typedef struct packed {
    byte_t      red;
    byte_t      green;
    byte_t      blue;
    logic [3:0] count_now;
    logic       request_ignored;
  } color_result_t;

  typedef struct {
    func_e       func;
    logic [15:0] prog;
    logic [2:0]  idx;
    byte_t       mtime;
    rgb_t        mcolor;
  } marker_req_t;

  class gradient_scoreboard;
    byte_t         tpts[MAXM];
    rgb_t          cols[MAXM];
    int unsigned   count;
    color_result_t pending[$];
    int            errors;

    function new();
      for (int i = 0; i < MAXM; i++) begin
        tpts[i] = (i < INIT_N) ? INIT_TIMES[i] : 8'd0;
        cols[i] = (i < INIT_N) ? INIT_COLORS[i] : 24'd0;
      end
      count = INIT_N;
      errors = 0;
    endfunction

    function automatic byte_t mix(int unsigned l, int unsigned r, int unsigned ratio);
      return byte_t'((l * (255 - ratio) + r * ratio) / 255);
    endfunction

    function void note_request(marker_req_t q);
      color_result_t res;
      int unsigned n, li, lo, hi, ratio, p, m, t;
      rgb_t cl, cr;
      res = '0;
      n = count;
      p = 32'(q.prog);
      case (q.func)
        FN_EVAL: begin
          li = 0; lo = 0; hi = 0;
          for (int i = 0; i + 1 < n; i++) begin
            li = i;
            lo = 32'({tpts[i], tpts[i]});
            hi = 32'({tpts[i+1], tpts[i+1]});
            if (p >= lo && p <= hi) break;
          end
          if (p <= lo) ratio = 0;
          else if (p >= hi) ratio = 255;
          else ratio = (255 * (p - lo)) / (hi - lo);
          cl = cols[li];
          cr = cols[(li + 1) % MAXM];
          res.red   = mix(32'(cl[23:16]), 32'(cr[23:16]), ratio);
          res.green = mix(32'(cl[15:8]), 32'(cr[15:8]), ratio);
          res.blue  = mix(32'(cl[7:0]), 32'(cr[7:0]), ratio);
        end
        FN_SET: begin
          if (q.idx < MAXM) begin
            tpts[q.idx] = q.mtime;
            cols[q.idx] = q.mcolor;
            if (q.idx == 0) cols[n-1] = q.mcolor;
            else if (q.idx == n - 1) cols[0] = q.mcolor;
          end
        end
        FN_ADD: begin
          if (n >= MAXM) res.request_ignored = 1'b1;
          else begin
            for (int i = 0; i < n; i++) tpts[i] = byte_t'((tpts[i] * (n - 1)) / n);
            tpts[n] = 8'd255;
            cols[n] = cols[0];
            count = n + 1;
          end
        end
        default: begin
          if (n <= 2) res.request_ignored = 1'b1;
          else begin
            m = n - 1;
            for (int i = 0; i + 1 < m; i++) begin
              t = (tpts[i] * m) / (m - 1);
              tpts[i] = (t > 255) ? 8'd255 : byte_t'(t);
            end
            tpts[m-1] = 8'd255;
            cols[m-1] = cols[0];
            count = m;
          end
        end
      endcase
      res.count_now = count[3:0];
      pending.push_back(res);
    endfunction

    function void check_result(color_result_t got);
      color_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.red !== want.red)
        $display("%0t: red expected %h actual %h", $time, want.red, got.red);
      if (got.green !== want.green)
        $display("%0t: green expected %h actual %h", $time, want.green, got.green);
      if (got.blue !== want.blue)
        $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
      if (got.count_now !== want.count_now)
        $display("%0t: count_now expected %0d actual %0d", $time, want.count_now,
                 got.count_now);
      if (got.request_ignored !== want.request_ignored)
        $display("%0t: request_ignored expected %b actual %b", $time,
                 want.request_ignored, got.request_ignored);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   quiet = 1'b0;
  gradient_scoreboard sb = new();

  cgt_in_if  in_bus();
  cgt_out_if out_bus();

  color_gradient_timeline_unit #(.MAX_MARKERS(MAXM)) DUT (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus.sink), .out_bus(out_bus.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.func = FN_EVAL;
    in_bus.time_progress = '0;
    in_bus.marker_index = '0;
    in_bus.marker_time = '0;
    in_bus.marker_red = '0;
    in_bus.marker_green = '0;
    in_bus.marker_blue = '0;
    out_bus.ready = 1'b0;
  end

  // result side: random stall bursts, none once quiet is set
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 13);
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      sb.check_result('{out_bus.red, out_bus.green, out_bus.blue,
                        out_bus.count_now, out_bus.request_ignored});
  end

  task automatic send_request(marker_req_t q);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.func <= q.func;
    in_bus.time_progress <= q.prog;
    in_bus.marker_index <= q.idx;
    in_bus.marker_time <= q.mtime;
    {in_bus.marker_red, in_bus.marker_green, in_bus.marker_blue} <= q.mcolor;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_request(q);
  endtask

  function automatic marker_req_t random_request();
    marker_req_t q;
    int sel;
    sel = $urandom_range(0, 9);
    q.func = (sel < 5) ? FN_EVAL : (sel < 7) ? FN_SET : (sel < 8) ? FN_ADD : FN_REMOVE;
    q.prog = ($urandom_range(0, 7) == 0) ? (($urandom_range(0, 1)) ? 16'hFFFF : 16'h0)
                                         : 16'($urandom);
    q.idx = ($urandom_range(0, 1)) ? 3'(sb.count - 1) : 3'($urandom_range(0, 7));
    if ($urandom_range(0, 2) == 0) q.idx = 3'd0;
    q.mtime = 8'($urandom);
    q.mcolor = 24'($urandom);
    return q;
  endfunction

  function automatic marker_req_t make_req(func_e f, logic [15:0] p, logic [2:0] ix,
                                           byte_t t, rgb_t c);
    marker_req_t q;
    q.func = f; q.prog = p; q.idx = ix; q.mtime = t; q.mcolor = c;
    return q;
  endfunction

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: reset table, extremes, falling pairs, refusals, mirroring
    send_request(make_req(FN_EVAL, 16'h0000, '0, '0, '0));
    send_request(make_req(FN_EVAL, 16'hFFFF, '0, '0, '0));
    send_request(make_req(FN_EVAL, 16'h5555, '0, '0, '0));
    send_request(make_req(FN_EVAL, 16'h8000, '0, '0, '0));
    send_request(make_req(FN_SET, '0, 3'd1, 8'd85, 24'hFFFFFF));
    send_request(make_req(FN_SET, '0, 3'd2, 8'd40, 24'h123456));
    send_request(make_req(FN_EVAL, 16'h6000, '0, '0, '0));
    send_request(make_req(FN_EVAL, 16'h3000, '0, '0, '0));
    send_request(make_req(FN_SET, '0, 3'd0, 8'd0, 24'hABCDEF));
    send_request(make_req(FN_SET, '0, 3'd3, 8'd255, 24'h00FF00));
    send_request(make_req(FN_SET, '0, 3'd7, 8'd200, 24'hFF00FF));
    for (int i = 0; i < 5; i++) send_request(make_req(FN_ADD, '0, '0, '0, '0));
    send_request(make_req(FN_EVAL, 16'hC000, '0, '0, '0));
    for (int i = 0; i < 7; i++) send_request(make_req(FN_REMOVE, '0, '0, '0, '0));
    send_request(make_req(FN_EVAL, 16'h1234, '0, '0, '0));
    send_request(make_req(FN_ADD, '0, '0, '0, '0));
    for (int i = 0; i < 2000; i++) begin
      if (i == 1700) quiet = 1'b1;
      send_request(random_request());
    end
    in_bus.valid <= 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("color_gradient_timeline_unit test passed");
    else
      $display("color_gradient_timeline_unit test failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("color_gradient_timeline_unit test failed");
    $finish;
  end
endmodule
